>>> rtl/core/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg - shared types and constants of the deadline task scheduler
// Command, operation, phase and acknowledge codes, register indexes,
// reset values and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package dts_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK   = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_TRIGGER = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_CHECK     = 3'd1,
    OP_CHECK_SEQ = 3'd2,
    OP_REPORT    = 3'd3,
    OP_DEPLOY    = 3'd4
  } op_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_BURN = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACK_TRIGGERED = 2'd0,
    ACK_REJECTED  = 2'd1,
    ACK_NONE      = 2'd2
  } ack_t;

  localparam logic [1:0] CFG_AUTO_DEPLOY = 2'd0;
  localparam logic [1:0] CFG_ARM_DELAY   = 2'd1;
  localparam logic [1:0] CFG_BURN_TIME   = 2'd2;

  localparam logic [31:0] ARM_DELAY_RESET = 32'd30_000_000;
  localparam logic [31:0] BURN_TIME_RESET = 32'd7_000_000;
  localparam logic [31:0] DEPLOY_LEAD_US  = 32'd100;

  // Slots reachable through the 3-bit task index
  localparam int MAX_SLOTS = 8;

  typedef struct packed {
    op_kind_t    kind;
    logic [2:0]  slot;
    logic [31:0] now;
    logic [31:0] delay;
  } op_t;

  typedef struct packed {
    logic        write;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

>>> rtl/core/dts_req_if.sv
// ----------------------------------------------------------------------------
// dts_req_if - request channel of the deadline task scheduler
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface dts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  task_index;
  logic [31:0] time_us;
  logic [31:0] delay_us;

  modport source (output valid, command, task_index, time_us, delay_us, input ready);
  modport sink   (input valid, command, task_index, time_us, delay_us, output ready);
endinterface

>>> rtl/core/dts_rsp_if.sv
// ----------------------------------------------------------------------------
// dts_rsp_if - result channel of the deadline task scheduler
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dts_rsp_if;
  logic       valid;
  logic       ready;
  logic       due;
  logic       burn_on;
  logic [1:0] deploy_phase;
  logic [1:0] ack_status;

  modport source (output valid, due, burn_on, deploy_phase, ack_status, input ready);
  modport sink   (input valid, due, burn_on, deploy_phase, ack_status, output ready);
endinterface

>>> rtl/core/dts_front.sv
// ----------------------------------------------------------------------------
// dts_front - request intake and classification
// Accepts request items while the queue has room and turns each into an
// operation code that the back end carries out without further decoding.
// ----------------------------------------------------------------------------
module dts_front #(
  parameter int NUM_SLOTS = 8
) (
  dts_req_if.sink         req,
  input  logic            full,
  output logic            push,
  output dts_pkg::op_t    op
);

  logic in_range;

  assign req.ready = !full;
  assign push      = req.valid && !full;
  assign in_range  = 32'(req.task_index) < NUM_SLOTS;

  always_comb begin
    op.slot  = req.task_index;
    op.now   = req.time_us;
    op.delay = req.delay_us;
    case (dts_pkg::cmd_t'(req.command))
      dts_pkg::CMD_CHECK: begin
        if (!in_range) begin
          op.kind = dts_pkg::OP_NOP;
        end else if (req.task_index == 3'd0) begin
          op.kind = dts_pkg::OP_CHECK_SEQ;
        end else begin
          op.kind = dts_pkg::OP_CHECK;
        end
      end
      dts_pkg::CMD_REPORT: begin
        // slot 0 reschedules itself; reports to it are dropped
        if (in_range && req.task_index != 3'd0) begin
          op.kind = dts_pkg::OP_REPORT;
        end else begin
          op.kind = dts_pkg::OP_NOP;
        end
      end
      dts_pkg::CMD_TRIGGER: begin
        // deploy always arms slot 0, whatever slot the item names
        op.slot = 3'd0;
        op.kind = dts_pkg::OP_DEPLOY;
      end
      default:             op.kind = dts_pkg::OP_NOP;
    endcase
  end

endmodule

>>> rtl/core/dts_queue.sv
// ----------------------------------------------------------------------------
// dts_queue - two-entry operation queue
// Decouples request intake from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module dts_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dts_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output dts_pkg::op_t head
);

  dts_pkg::op_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_op;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> full)
    else $error("queue did not fill");

endmodule

>>> rtl/core/dts_back.sv
// ----------------------------------------------------------------------------
// dts_back - slot table, deploy sequencer and result register
// Pops one operation per cycle when the result register is free, does the
// slot read-modify-write and the sequencer step, and registers the result.
// ----------------------------------------------------------------------------
module dts_back #(
  parameter int NUM_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dts_pkg::cfg_wr_t  cfg,
  input  logic              not_empty,
  input  dts_pkg::op_t      op,
  output logic              pop,
  dts_rsp_if.source         rsp
);

  localparam int DEPTH = (NUM_SLOTS < dts_pkg::MAX_SLOTS) ? NUM_SLOTS : dts_pkg::MAX_SLOTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]      due_time [DEPTH];
  logic [DEPTH-1:0] enabled;
  dts_pkg::phase_t  phase;
  logic             burnwire;
  logic             auto_deploy;
  logic [31:0]      arm_delay_us;
  logic [31:0]      burn_time_us;
  logic             rsp_valid;

  logic [IDX_W-1:0] idx;
  logic [31:0]      cur_time;
  logic [31:0]      diff;
  logic             slot_en;
  logic             due_hit;
  logic [31:0]      addend;
  logic [31:0]      new_time;
  logic             wr_time;
  logic             wr_disable;
  logic             wr_enable;
  dts_pkg::phase_t  phase_next;
  logic             burnwire_next;
  dts_pkg::ack_t    ack;

  assign pop       = not_empty && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;

  assign idx      = op.slot[IDX_W-1:0];
  assign cur_time = due_time[idx];
  assign slot_en  = enabled[idx];
  // past due in wraparound time: the difference is negative
  assign diff     = cur_time - op.now;
  assign new_time = op.now + addend;

  always_comb begin
    phase_next    = phase;
    burnwire_next = burnwire;
    addend        = op.delay;
    due_hit       = 1'b0;
    ack           = dts_pkg::ACK_NONE;
    wr_time       = 1'b0;
    wr_disable    = 1'b0;
    wr_enable     = 1'b0;
    case (op.kind)
      dts_pkg::OP_CHECK: due_hit = slot_en && diff[31];
      dts_pkg::OP_CHECK_SEQ: begin
        due_hit = slot_en && diff[31];
        if (due_hit) begin
          case (phase)
            dts_pkg::PH_IDLE: begin
              if (auto_deploy) begin
                phase_next = dts_pkg::PH_WAIT;
                addend     = arm_delay_us;
              end else begin
                addend = 32'd0;
              end
            end
            dts_pkg::PH_WAIT: begin
              burnwire_next = 1'b1;
              phase_next    = dts_pkg::PH_BURN;
              addend        = burn_time_us;
            end
            dts_pkg::PH_BURN: begin
              burnwire_next = 1'b0;
              phase_next    = dts_pkg::PH_IDLE;
              addend        = 32'd0;
            end
            default: addend = 32'd0;
          endcase
          wr_disable = addend == 32'd0;
          wr_time    = addend != 32'd0;
        end
      end
      dts_pkg::OP_REPORT: begin
        wr_disable = op.delay == 32'd0;
        wr_time    = op.delay != 32'd0;
      end
      dts_pkg::OP_DEPLOY: begin
        if (phase == dts_pkg::PH_IDLE) begin
          phase_next = dts_pkg::PH_WAIT;
          addend     = dts_pkg::DEPLOY_LEAD_US;
          wr_time    = 1'b1;
          wr_enable  = 1'b1;
          ack        = dts_pkg::ACK_TRIGGERED;
        end else begin
          ack = dts_pkg::ACK_REJECTED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        due_time[i] <= 32'd0;
      end
      enabled      <= '1;
      phase        <= dts_pkg::PH_IDLE;
      burnwire     <= 1'b0;
      auto_deploy  <= 1'b0;
      arm_delay_us <= dts_pkg::ARM_DELAY_RESET;
      burn_time_us <= dts_pkg::BURN_TIME_RESET;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.write) begin
        case (cfg.index)
          dts_pkg::CFG_AUTO_DEPLOY: auto_deploy  <= cfg.data[0];
          dts_pkg::CFG_ARM_DELAY:   arm_delay_us <= cfg.data;
          dts_pkg::CFG_BURN_TIME:   burn_time_us <= cfg.data;
          default: ;
        endcase
      end
      if (pop) begin
        if (wr_time) begin
          due_time[idx] <= new_time;
        end
        if (wr_disable) begin
          enabled[idx] <= 1'b0;
        end else if (wr_enable) begin
          enabled[idx] <= 1'b1;
        end
        phase            <= phase_next;
        burnwire         <= burnwire_next;
        rsp.due          <= due_hit;
        rsp.burn_on      <= burnwire_next;
        rsp.deploy_phase <= phase_next;
        rsp.ack_status   <= ack;
        rsp_valid        <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_burn_phase: assert property (@(posedge clk) disable iff (rst)
    burnwire == (phase == dts_pkg::PH_BURN))
    else $error("burnwire level disagrees with sequencer phase");
  a_deploy_arms: assert property (@(posedge clk) disable iff (rst)
    (pop && op.kind == dts_pkg::OP_DEPLOY && phase == dts_pkg::PH_IDLE)
    |=> (enabled[0] && phase == dts_pkg::PH_WAIT && rsp.valid && !rsp.due))
    else $error("deploy did not arm slot 0");
  a_due_ack: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.due) |-> rsp.ack_status == dts_pkg::ACK_NONE)
    else $error("due result carries a deploy acknowledge");

endmodule

>>> rtl/core/deadline_task_scheduler_with_deploy.sv
// ----------------------------------------------------------------------------
// deadline_task_scheduler_with_deploy - task deadline table with deploy sequencer
// Checks and reschedules task slots in wraparound microsecond time; slot 0
// drives the burnwire deploy sequence.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (check, report, deploy) per handshake; rsp
//   returns exactly one result item per request, in order. Registers are
//   written through cfg_write/cfg_index/cfg_data; the user must write them
//   only while the block is idle; the block itself does not enforce this.
//   An accepted item goes through the queue and the result register to rsp.
//   Throughput: one item per cycle while rsp takes results; each item does one
//   slot read-modify-write, 32-bit subtract/compare and 32-bit add in execution.
//   A two-entry queue sits between intake and execution; when rsp stalls,
//   the result register holds, the queue fills, then req.ready drops.
//   Reset clears the queue, enables all slots with due time zero, puts the
//   sequencer in idle with the burnwire off and loads default register
//   values (auto-deploy off, 30 s arm delay, 7 s burn time).
// ----------------------------------------------------------------------------
module deadline_task_scheduler_with_deploy #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  dts_req_if.sink     req,
  dts_rsp_if.source   rsp
);

  dts_pkg::op_t     front_op;
  dts_pkg::op_t     head_op;
  dts_pkg::cfg_wr_t cfg;
  logic             push;
  logic             full;
  logic             pop;
  logic             not_empty;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  dts_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .req  (req),
    .full (full),
    .push (push),
    .op   (front_op)
  );

  dts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (front_op),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head_op)
  );

  dts_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .not_empty (not_empty),
    .op        (head_op),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

>>> dv/deadline_task_scheduler_with_deploy_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_task_scheduler_with_deploy_tb - regression bench for the scheduler
// Drives check, report and deploy items into the request channel with random
// gaps, predicts every status item from a cycle-free copy of the slot table
// and deploy sequencer, and compares the status channel in order. Several
// register settings are applied between drained phases.
// ----------------------------------------------------------------------------
module deadline_task_scheduler_with_deploy_tb;

  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  localparam logic [31:0] HALF_RANGE      = 32'h7FFF_FFFF;
  localparam int          ITEMS_PER_PHASE = 148;
  localparam int          CYCLE_LIMIT     = 500_000;
  localparam int          HOLD_CYCLES     = 200;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  task_index;
    logic [31:0] time_us;
    logic [31:0] delay_us;
  } sched_item_t;

  typedef struct packed {
    logic       due;
    logic       burn_on;
    logic [1:0] deploy_phase;
    logic [1:0] ack_status;
  } sched_status_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  dts_req_if req_ch ();
  dts_rsp_if rsp_ch ();

  deadline_task_scheduler_with_deploy i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the slot table, sequencer and registers
  logic [31:0]      slot_due_at [dts_pkg::MAX_SLOTS];
  logic             slot_live   [dts_pkg::MAX_SLOTS];
  dts_pkg::phase_t  seq_phase;
  logic             burn_level;
  logic             auto_arm;
  logic [31:0]      arm_wait_us;
  logic [31:0]      burn_span_us;

  sched_item_t   pending_items [$];
  sched_status_t awaited_status [$];

  logic [31:0] wall_us;
  int          sent_count;
  int          gap_left;
  int          stall_left;
  int          hold_left;
  int          next_hold_at;
  int          cycle_count;
  int          status_count;
  int          fail_count;
  int          due_count;
  int          burn_count;
  int          deploy_count;
  int          reject_count;

  // Work out the status item for one accepted item and advance the shadow state
  task automatic schedule_item(input sched_item_t it);
    sched_status_t res;
    logic [31:0]   lead;
    logic [31:0]   step_us;
    res = '0;
    res.ack_status = dts_pkg::ACK_NONE;
    step_us = '0;
    if (it.command == dts_pkg::CMD_CHECK) begin
      lead = slot_due_at[it.task_index] - it.time_us;
      if (slot_live[it.task_index] && lead > HALF_RANGE) begin
        res.due = 1'b1;
        if (it.task_index == 3'd0) begin
          case (seq_phase)
            dts_pkg::PH_IDLE: begin
              if (auto_arm) begin
                seq_phase = dts_pkg::PH_WAIT;
                step_us = arm_wait_us;
              end
            end
            dts_pkg::PH_WAIT: begin
              burn_level = 1'b1;
              seq_phase = dts_pkg::PH_BURN;
              step_us = burn_span_us;
            end
            dts_pkg::PH_BURN: begin
              burn_level = 1'b0;
              seq_phase = dts_pkg::PH_IDLE;
            end
            default: step_us = '0;
          endcase
          // zero delay retires slot 0 in whatever phase it landed in
          if (step_us == 32'd0) slot_live[0] = 1'b0;
          else slot_due_at[0] = it.time_us + step_us;
        end
      end
    end else if (it.command == dts_pkg::CMD_REPORT) begin
      if (it.task_index != 3'd0) begin
        if (it.delay_us == 32'd0) slot_live[it.task_index] = 1'b0;
        else slot_due_at[it.task_index] = it.time_us + it.delay_us;
      end
    end else if (it.command == dts_pkg::CMD_TRIGGER) begin
      if (seq_phase == dts_pkg::PH_IDLE) begin
        seq_phase = dts_pkg::PH_WAIT;
        slot_live[0] = 1'b1;
        slot_due_at[0] = it.time_us + dts_pkg::DEPLOY_LEAD_US;
        res.ack_status = dts_pkg::ACK_TRIGGERED;
      end else begin
        res.ack_status = dts_pkg::ACK_REJECTED;
      end
    end
    res.burn_on = burn_level;
    res.deploy_phase = seq_phase;
    awaited_status.push_back(res);
  endtask

  // Mostly back-to-back, some short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] report_delay(input logic [2:0] slot);
    int r;
    r = $urandom_range(0, 99);
    // only the top slots get retired, so the others keep rescheduling
    if (slot >= 3'd6 && r < 12) return 32'd0;
    if (r < 70) return $urandom_range(1, 1000);
    if (r < 88) return $urandom();
    return HALF_RANGE + $urandom_range(0, 2) - 32'd1;
  endfunction

  function automatic sched_item_t random_item();
    sched_item_t it;
    int          pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) wall_us = $urandom();
    else wall_us = wall_us + $urandom_range(0, 300);
    it.command = dts_pkg::CMD_CHECK;
    it.time_us = wall_us;
    it.delay_us = $urandom();
    it.task_index = 3'($urandom_range(1, 7));
    if (pick < 45) begin
      if (pick < 25) it.task_index = 3'd0;
    end else if (pick < 80) begin
      it.command = dts_pkg::CMD_REPORT;
      it.delay_us = report_delay(it.task_index);
      if (pick >= 78) it.task_index = 3'd0;
    end else if (pick < 92) begin
      it.command = dts_pkg::CMD_TRIGGER;
      it.task_index = 3'($urandom_range(0, 7));
    end else if (pick < 96) begin
      it.command = CMD_UNUSED;
      it.task_index = 3'($urandom_range(0, 7));
      it.time_us = $urandom();
    end else begin
      it.task_index = 3'($urandom_range(0, 7));
      it.time_us = $urandom();
    end
    return it;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [2:0] slot,
                          input logic [31:0] now, input logic [31:0] delay);
    sched_item_t it;
    it.command = cmd;
    it.task_index = slot;
    it.time_us = now;
    it.delay_us = delay;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dts_pkg::CFG_AUTO_DEPLOY: auto_arm = data[0];
      dts_pkg::CFG_ARM_DELAY:   arm_wait_us = data;
      dts_pkg::CFG_BURN_TIME:   burn_span_us = data;
      default:                  ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || req_ch.valid || awaited_status.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_setting(input logic auto_on, input logic [31:0] arm,
                             input logic [31:0] burn, input logic [31:0] start_us);
    // upper data bits are don't-care for the one-bit register
    write_reg(dts_pkg::CFG_AUTO_DEPLOY, {31'($urandom_range(0, 32'h7FFF_FFFF)), auto_on});
    write_reg(dts_pkg::CFG_ARM_DELAY, arm);
    write_reg(dts_pkg::CFG_BURN_TIME, burn);
    @(negedge clk);
    wall_us = start_us;
    repeat (ITEMS_PER_PHASE) pending_items.push_back(random_item());
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.command <= '0;
      req_ch.task_index <= '0;
      req_ch.time_us <= '0;
      req_ch.delay_us <= '0;
      gap_left <= 0;
      sent_count <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        schedule_item({req_ch.command, req_ch.task_index, req_ch.time_us, req_ch.delay_us});
        sent_count <= sent_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          sched_item_t nxt;
          nxt = pending_items.pop_front();
          req_ch.command <= nxt.command;
          req_ch.task_index <= nxt.task_index;
          req_ch.time_us <= nxt.time_us;
          req_ch.delay_us <= nxt.delay_us;
          req_ch.valid <= 1'b1;
          // every fifth stretch of items runs without gaps
          gap_left <= ((sent_count / 80) % 5 == 2) ? 0 : pick_pause();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: lets the block fill up and push back on requests
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      next_hold_at <= 150;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (sent_count >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 400;
    end
  end

  // Status monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        sched_status_t got;
        sched_status_t exp;
        got = {rsp_ch.due, rsp_ch.burn_on, rsp_ch.deploy_phase, rsp_ch.ack_status};
        status_count++;
        if (awaited_status.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("status item %0d arrived with nothing pending", status_count);
        end else begin
          exp = awaited_status.pop_front();
          if (got !== exp) begin
            fail_count++;
            if (fail_count <= 10)
              $display("status item %0d: due %b/%b burn %b/%b phase %0d/%0d ack %0d/%0d %s",
                       status_count, exp.due, got.due, exp.burn_on, got.burn_on,
                       exp.deploy_phase, got.deploy_phase, exp.ack_status, got.ack_status,
                       "(expected/actual)");
          end
          due_count += exp.due;
          burn_count += exp.burn_on;
          if (exp.ack_status == dts_pkg::ACK_TRIGGERED) deploy_count++;
          if (exp.ack_status == dts_pkg::ACK_REJECTED) reject_count++;
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ((cycle_count / 150) % 5 != 3 && $urandom_range(0, 2) == 0)
          stall_left <= pick_pause();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status items pending",
               cycle_count, awaited_status.size());
      $display("deadline_task_scheduler_with_deploy regression: fail");
      $finish;
    end
  end

  initial begin
    logic auto_first;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.task_index = '0;
    req_ch.time_us = '0;
    req_ch.delay_us = '0;
    rsp_ch.ready = 1'b0;
    cycle_count = 0;
    status_count = 0;
    fail_count = 0;
    due_count = 0;
    burn_count = 0;
    deploy_count = 0;
    reject_count = 0;
    for (int s = 0; s < dts_pkg::MAX_SLOTS; s++) begin
      slot_due_at[s] = '0;
      slot_live[s] = 1'b1;
    end
    seq_phase = dts_pkg::PH_IDLE;
    burn_level = 1'b0;
    auto_arm = 1'b0;
    arm_wait_us = dts_pkg::ARM_DELAY_RESET;
    burn_span_us = dts_pkg::BURN_TIME_RESET;
    wall_us = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Slot 0 is idle and live only right after reset, so one run sees either
    // the auto-deploy start (with the reset delays) or the plain retire.
    auto_first = 1'($urandom_range(0, 1));
    if (auto_first) write_reg(dts_pkg::CFG_AUTO_DEPLOY, 32'd1);
    @(negedge clk);

    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'd0, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'd1, 32'hFFFF_FFFF);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'd2, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'd30_000_002, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'd37_000_003, 32'd0);
    // wraparound boundary on untouched slots (due time zero)
    add_item(dts_pkg::CMD_CHECK, 3'd7, 32'h8000_0000, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd3, 32'h7FFF_FFFF, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd5, 32'h8000_0001, 32'd0);
    add_item(dts_pkg::CMD_REPORT, 3'd0, 32'd5, 32'd5);
    add_item(dts_pkg::CMD_REPORT, 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(dts_pkg::CMD_CHECK, 3'd2, 32'hFFFF_FFFD, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd2, 32'hFFFF_FFFE, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd2, 32'hFFFF_FFFF, 32'd0);
    add_item(dts_pkg::CMD_REPORT, 3'd4, 32'd0, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd4, 32'h8000_0000, 32'd0);
    add_item(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(dts_pkg::CMD_TRIGGER, 3'd0, 32'hFFFF_FFC0, 32'd0);
    add_item(dts_pkg::CMD_TRIGGER, 3'd1, 32'hFFFF_FFC1, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'h0000_0024, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'h0000_0025, 32'd0);
    add_item(dts_pkg::CMD_CHECK, 3'd0, 32'h0000_0025 + dts_pkg::BURN_TIME_RESET + 32'd1,
             32'd0);
    add_item(dts_pkg::CMD_TRIGGER, 3'd7, 32'd0, 32'hFFFF_FFFF);
    wait_drained();

    run_setting(1'b1, 32'd300, 32'd200, $urandom());
    run_setting(1'b0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_F000);
    run_setting(1'b1, 32'hFFFF_FFFF, 32'd1, $urandom());
    run_setting(1'b0, $urandom_range(50, 800), $urandom_range(50, 800), $urandom());
    run_setting(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, $urandom());
    run_setting(1'b0, 32'd500, 32'd350, $urandom());
    // zero delays park the sequencer in an active phase for good: run it last
    run_setting(1'b1, 32'd0, 32'd0, $urandom());

    repeat (10) @(posedge clk);
    $display("covered %0d items over 8 register settings, auto-deploy start %0s",
             sent_count, auto_first ? "taken" : "skipped");
    $display("saw %0d due slots, %0d burn-on items, %0d deploys taken, %0d rejected",
             due_count, burn_count, deploy_count, reject_count);
    if (fail_count == 0 && awaited_status.size() == 0)
      $display("deadline_task_scheduler_with_deploy regression: pass");
    else
      $display("deadline_task_scheduler_with_deploy regression: fail");
    $finish;
  end

endmodule
